>>> rtl/fud_pkg.sv
`timescale 1ns / 1ps
// Package for the form-urlencoded decoder: character codes, decoder state
// and result types, and the hex digit rule. No dependencies.
package fud_pkg;

    // Character codes
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_UPA  = 8'h41;
    localparam logic [7:0] CASE_MASK = 8'hDF;
    localparam logic [7:0] ALPHA_OFFSET = 8'd55;
    localparam logic [7:0] DIGIT_OFFSET = 8'd48;

    // Percent escape progress
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic       part_is_value;
        esc_phase_t escape_phase;
        logic [7:0] high_digit;
        logic       pair_nonempty;
    } fud_state_t;

    localparam fud_state_t STATE_RESET = '{
        part_is_value: 1'b0,
        escape_phase:  ESC_NONE,
        high_digit:    8'd0,
        pair_nonempty: 1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       in_value;
        logic       pair_end;
        logic       bad_escape;
    } fud_result_t;

    // Unchecked hex digit value, mod 256
    function automatic logic [7:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_UPA)
        begin
            v = (c & CASE_MASK) - ALPHA_OFFSET;
        end
        else
        begin
            v = c - DIGIT_OFFSET;
        end
        return v;
    endfunction

endpackage

>>> rtl/fud_in_if.sv
`timescale 1ns / 1ps
// Input channel of the form-urlencoded decoder: one body byte per request.
// Depends on nothing.
interface fud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

>>> rtl/fud_out_if.sv
`timescale 1ns / 1ps
// Output channel of the form-urlencoded decoder: one decoded result per request.
// Depends on nothing.
interface fud_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_value;
    logic       pair_end;
    logic       bad_escape;

    modport source (output valid, output out_byte, output byte_valid, output in_value,
                    output pair_end, output bad_escape, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input in_value,
                    input pair_end, input bad_escape, output ready);
endinterface

>>> rtl/fud_step.sv
`timescale 1ns / 1ps
// One decode step: next decoder state and the result for one body byte.
// Depends on fud_pkg.
module fud_step (
    input  fud_pkg::fud_state_t  state,
    input  logic [7:0]           in_byte,
    input  logic                 last,
    output fud_pkg::fud_state_t  state_next,
    output fud_pkg::fud_result_t result,
    output logic                 has_result
);
    import fud_pkg::*;

    logic [7:0] c;
    logic [7:0] hv_hi;
    logic [7:0] hv_lo;
    logic [7:0] esc_byte;
    logic       valid;
    logic       bad;
    logic       pair_done;
    logic [7:0] data_byte;
    fud_state_t st;

    // '+' becomes a space before anything else
    assign c = (in_byte == CH_PLUS) ? CH_SP : in_byte;

    // Escape byte: 16 * v(hi) + v(lo), mod 256
    assign hv_hi    = hex_val(state.high_digit);
    assign hv_lo    = hex_val(c);
    assign esc_byte = {hv_hi[3:0], 4'b0000} + hv_lo;

    always_comb
    begin
        st        = state;
        valid     = 1'b0;
        bad       = 1'b0;
        pair_done = 1'b0;
        data_byte = 8'd0;
        if (in_byte == CH_AMP || in_byte == CH_SEMI)
        begin
            // Pair delimiter
            bad       = (state.escape_phase != ESC_NONE);
            pair_done = state.pair_nonempty;
            st        = STATE_RESET;
        end
        else
        begin
            st.pair_nonempty = 1'b1;
            if (c == CH_EQ && !state.part_is_value)
            begin
                // Name/value split; cuts a pending escape
                bad              = (state.escape_phase != ESC_NONE);
                st.escape_phase  = ESC_NONE;
                st.part_is_value = 1'b1;
            end
            else
            begin
                unique case (state.escape_phase)
                    ESC_HIGH:
                    begin
                        st.high_digit   = c;
                        st.escape_phase = ESC_LOW;
                    end
                    ESC_LOW:
                    begin
                        data_byte       = esc_byte;
                        valid           = 1'b1;
                        st.escape_phase = ESC_NONE;
                    end
                    default:
                    begin
                        if (c == CH_PCT)
                        begin
                            st.escape_phase = ESC_HIGH;
                        end
                        else
                        begin
                            data_byte = c;
                            valid     = 1'b1;
                        end
                    end
                endcase
            end
            // End of body closes the pair
            if (last)
            begin
                if (st.escape_phase != ESC_NONE)
                begin
                    bad = 1'b1;
                end
                pair_done = 1'b1;
                st        = STATE_RESET;
            end
        end
    end

    assign state_next        = st;
    assign result.out_byte   = data_byte;
    assign result.byte_valid = valid;
    assign result.in_value   = state.part_is_value;
    assign result.pair_end   = pair_done;
    assign result.bad_escape = bad;
    assign has_result        = valid | bad | pair_done;

endmodule

>>> rtl/form_urlencoded_decoder.sv
`timescale 1ns / 1ps
// Streaming decoder for an application/x-www-form-urlencoded body.
// Depends on fud_pkg, fud_in_if, fud_out_if and fud_step.
//
// Usage:
//   body   : one raw byte per request, with last marking the final byte.
//   result : at most one decoded item per body byte: a decoded byte tagged
//            name or value, a pair-end mark, and a dropped-escape flag.
//            Bytes that only advance the parser ('%', first hex digit,
//            '=' split, empty delimiters) produce no result.
//   Path: a byte accepted into the input register is decoded and loaded
//   into the output register once that register is free, and its result
//   is offered from there.
//   Throughput: one byte per cycle while results are taken; the per-byte
//   parser state is a single register updated by one short step of logic per byte.
//   Reset: clears the input and output valid flags and returns the parser to
//   the start of a name with no escape pending.
//   Stall: while a result waits unaccepted, the input register holds its
//   byte and body.ready drops once that register is full; no data is lost.
module form_urlencoded_decoder (
    input  logic        clk,
    input  logic        rst_n,
    fud_in_if.sink      body,
    fud_out_if.source   result
);
    import fud_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    fud_state_t  state_reg;
    fud_state_t  state_next;
    logic        out_valid_reg;
    fud_result_t result_reg;
    fud_result_t step_result;
    logic        step_has_result;
    logic        out_free;
    logic        s1_advance;
    logic        in_fire;

    fud_step u_step (
        .state      (state_reg),
        .in_byte    (s1_byte_reg),
        .last       (s1_last_reg),
        .state_next (state_next),
        .result     (step_result),
        .has_result (step_has_result)
    );

    // Handshake control
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign body.ready = !s1_valid_reg || out_free;
    assign in_fire    = body.valid && body.ready;

    // Control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (body.ready)
            begin
                s1_valid_reg <= body.valid;
            end
            if (s1_advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_advance && step_has_result;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= body.in_byte;
            s1_last_reg <= body.last;
        end
        if (s1_advance && step_has_result && out_free)
        begin
            result_reg <= step_result;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = result_reg.out_byte;
    assign result.byte_valid = result_reg.byte_valid;
    assign result.in_value   = result_reg.in_value;
    assign result.pair_end   = result_reg.pair_end;
    assign result.bad_escape = result_reg.bad_escape;

    // A result always carries at least one flag
    a_result_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.byte_valid || result_reg.pair_end ||
                           result_reg.bad_escape))
        else $error("result offered with no flag set");

    // Final byte of a body returns the parser to its reset state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (state_reg == STATE_RESET))
        else $error("parser state not cleared after final byte");

    // Final byte always ends the pair (unless a delimiter already did)
    a_last_ends_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg && s1_byte_reg != CH_AMP && s1_byte_reg != CH_SEMI)
        |=> (out_valid_reg && result_reg.pair_end))
        else $error("final byte did not mark pair end");

endmodule

>>> bench/tb_form_urlencoded_decoder.sv
`timescale 1ns / 1ps
// Testbench for form_urlencoded_decoder: a bursty body driver, a stalling result sink
// and a built-in decoder predictor that checks every result field.
// Depends on fud_pkg, fud_in_if, fud_out_if and the decoder RTL.
module tb_form_urlencoded_decoder;

    import fud_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       lst;
        bit         drain_first;  // wait for all results before offering this one
    } body_req_t;

    logic clk;
    logic rst_n;

    fud_in_if  body_if ();
    fud_out_if result_if ();

    form_urlencoded_decoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_if.sink),
        .result (result_if.source)
    );

    body_req_t   pending_body[$];
    fud_result_t decoded_due[$];
    logic [7:0]  body_buf[$];
    int          sent_count;
    int          total_items;
    int          errors;
    int          body_index;

    string plain_chars = "abcxyzABCXYZ0129_-.*~";
    string hex_chars   = "0123456789abcdefABCDEF";

    // Decoder state kept by the predictor
    logic       part_val;
    esc_phase_t esc_now;
    logic [7:0] first_digit;
    logic       pair_used;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_pair_state();
        part_val    = 1'b0;
        esc_now     = ESC_NONE;
        first_digit = 8'd0;
        pair_used   = 1'b0;
    endfunction

    // Unchecked digit weight: letters fold to upper case, the rest count from '0'
    function automatic logic [7:0] digit_weight(input logic [7:0] c);
        if (c < CH_UPA)
        begin
            return c - DIGIT_OFFSET;
        end
        return (c & CASE_MASK) - ALPHA_OFFSET;
    endfunction

    // Advance the predictor by one body byte; emit tells whether a result follows
    function automatic void decode_request(input logic [7:0] raw, input logic lst,
                                           output bit emit, output fud_result_t res);
        logic [7:0] ch;
        logic [7:0] hi_w;
        logic [7:0] lo_w;
        res = '0;
        res.in_value = part_val;
        if (raw == CH_AMP || raw == CH_SEMI)
        begin
            res.bad_escape = (esc_now != ESC_NONE);
            res.pair_end   = pair_used;
            clear_pair_state();
        end
        else
        begin
            ch = (raw == CH_PLUS) ? CH_SP : raw;
            pair_used = 1'b1;
            if (ch == CH_EQ && !part_val)
            begin
                // name/value split; a pending escape is lost
                if (esc_now != ESC_NONE)
                begin
                    res.bad_escape = 1'b1;
                end
                esc_now  = ESC_NONE;
                part_val = 1'b1;
            end
            else if (esc_now == ESC_HIGH)
            begin
                first_digit = ch;
                esc_now     = ESC_LOW;
            end
            else if (esc_now == ESC_LOW)
            begin
                hi_w = digit_weight(first_digit);
                lo_w = digit_weight(ch);
                res.out_byte   = {hi_w[3:0], 4'h0} + lo_w;
                res.byte_valid = 1'b1;
                esc_now        = ESC_NONE;
            end
            else if (ch == CH_PCT)
            begin
                esc_now = ESC_HIGH;
            end
            else
            begin
                res.out_byte   = ch;
                res.byte_valid = 1'b1;
            end
            // end of body closes the pair and drops any partial escape
            if (lst)
            begin
                if (esc_now != ESC_NONE)
                begin
                    res.bad_escape = 1'b1;
                end
                res.pair_end = 1'b1;
                clear_pair_state();
            end
        end
        emit = res.byte_valid | res.pair_end | res.bad_escape;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
        end
    endfunction

    task automatic push_req(input logic [7:0] data, input logic lst, input bit drain);
        body_req_t req;
        req.data        = data;
        req.lst         = lst;
        req.drain_first = drain;
        pending_body.insert(pending_body.size(), req);
    endtask

    // Append one byte to the body under construction
    task automatic append_byte(input logic [7:0] b);
        body_buf.insert(body_buf.size(), b);
    endtask

    task automatic push_text(input string s, input bit ends_body);
        for (int i = 0; i < s.len(); i++)
        begin
            push_req(s.getc(i), ends_body && (i == s.len() - 1), 1'b0);
        end
    endtask

    // One item of a name or value: a character, sometimes an escape or raw noise
    task automatic add_text_byte(input bit noisy);
        int pick;
        pick = $urandom_range(0, 15);
        if (noisy && pick < 4)
        begin
            append_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 10)
        begin
            append_byte(plain_chars.getc($urandom_range(0, plain_chars.len() - 1)));
        end
        else if (pick < 12)
        begin
            append_byte(CH_PLUS);
        end
        else if (pick < 15)
        begin
            append_byte(CH_PCT);
            append_byte(hex_chars.getc($urandom_range(0, hex_chars.len() - 1)));
            append_byte(hex_chars.getc($urandom_range(0, hex_chars.len() - 1)));
        end
        else
        begin
            append_byte(CH_EQ);
        end
    endtask

    function automatic logic [7:0] pick_delim();
        return $urandom_range(0, 1) ? CH_AMP : CH_SEMI;
    endfunction

    // A body of one to four name=value pairs; some bodies carry noise
    task automatic add_random_body();
        bit noisy;
        bit drain;
        int pairs;
        int n;
        noisy = ($urandom_range(0, 4) == 0);
        pairs = $urandom_range(1, 4);
        for (int p = 0; p < pairs; p++)
        begin
            if (p > 0 || $urandom_range(0, 7) == 0)
            begin
                append_byte(pick_delim());
                if ($urandom_range(0, 9) == 0)
                begin
                    append_byte(pick_delim());
                end
            end
            n = $urandom_range(0, 5);
            for (int k = 0; k < n; k++)
            begin
                add_text_byte(noisy);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                append_byte(CH_EQ);
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++)
                begin
                    add_text_byte(noisy);
                end
            end
        end
        if ($urandom_range(0, 5) == 0)
        begin
            append_byte(pick_delim());
        end
        if (body_buf.size() == 0)
        begin
            append_byte(plain_chars.getc(0));
        end
        drain = (body_index % 12 == 5);
        body_index++;
        foreach (body_buf[i])
        begin
            push_req(body_buf[i], i == body_buf.size() - 1, drain && i == 0);
        end
        body_buf.delete();
    endtask

    // Body driver: bursts of requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_body
        body_req_t   req;
        fud_result_t res;
        bit          emit;
        logic        next_valid;
        logic [7:0]  next_byte;
        logic        next_last;
        static int   burst_left = 0;
        static int   gap_left = 0;
        if (!rst_n)
        begin
            body_if.valid   <= 1'b0;
            body_if.in_byte <= 8'd0;
            body_if.last    <= 1'b0;
        end
        else
        begin
            next_valid = body_if.valid;
            next_byte  = body_if.in_byte;
            next_last  = body_if.last;
            if (body_if.valid && body_if.ready)
            begin
                decode_request(body_if.in_byte, body_if.last, emit, res);
                if (emit)
                begin
                    decoded_due.insert(decoded_due.size(), res);
                end
                sent_count++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_body.size() != 0 &&
                         !(pending_body[0].drain_first && decoded_due.size() != 0))
                begin
                    req        = pending_body.pop_front();
                    next_valid = 1'b1;
                    next_byte  = req.data;
                    next_last  = req.lst;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                                  : $urandom_range(1, 10);
                        gap_left   = $urandom_range(0, 5);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
            body_if.valid   <= next_valid;
            body_if.in_byte <= next_byte;
            body_if.last    <= next_last;
        end
    end

    // Result sink: stall pattern chosen by rx_cycles[8:7], plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin : drive_result_ready
        logic        next_ready;
        static logic [15:0] rx_cycles = 16'd0;
        static int   hold_left = 0;
        static int   holds_done = 0;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            rx_cycles++;
            if (hold_left == 0 && holds_done < 2 && sent_count >= (holds_done + 1) * 350)
            begin
                hold_left = 64;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                case (rx_cycles[8:7])
                    2'd0:    next_ready = 1'b1;
                    2'd1:    next_ready = ($urandom_range(0, 3) != 0);
                    2'd2:    next_ready = 1'($urandom_range(0, 1));
                    default: next_ready = (rx_cycles[2:0] != 3'd3) && (rx_cycles[4:3] != 2'd0);
                endcase
            end
            result_if.ready <= next_ready;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : check_results
        fud_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (decoded_due.size() == 0)
            begin
                $error("result with nothing expected: out_byte %0h", result_if.out_byte);
                errors++;
            end
            else
            begin
                want = decoded_due.pop_front();
                check_field("out_byte", want.out_byte, result_if.out_byte);
                check_field("byte_valid", {7'd0, want.byte_valid},
                            {7'd0, result_if.byte_valid});
                check_field("in_value", {7'd0, want.in_value}, {7'd0, result_if.in_value});
                check_field("pair_end", {7'd0, want.pair_end}, {7'd0, result_if.pair_end});
                check_field("bad_escape", {7'd0, want.bad_escape},
                            {7'd0, result_if.bad_escape});
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        rst_n             = 1'b0;
        sent_count        = 0;
        errors            = 0;
        body_index        = 0;
        clear_pair_state();

        // empty pairs, '+', split, '%' and '=' as escape digits, escape cut by
        // a delimiter, by '=' in the name and by end of input
        push_text("&;a+=%%=%4&x%=1%", 1'b1);
        // NUL and 0xFF as data and as escape digits, escape closed on the last byte
        push_req(8'h00, 1'b0, 1'b0);
        push_req(8'hFF, 1'b0, 1'b0);
        push_req(CH_PCT, 1'b0, 1'b0);
        push_req(8'h00, 1'b0, 1'b0);
        push_req(8'hFF, 1'b1, 1'b0);
        push_text("A", 1'b1);
        push_text("%6", 1'b1);
        push_text("=", 1'b1);

        while (pending_body.size() < 850)
        begin
            add_random_body();
        end
        total_items = pending_body.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_items)
        begin
            @(posedge clk);
        end
        while (decoded_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (errors == 0 && decoded_due.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
